>>> rtl/packet_integer_decoder_core_assert.svh
// Assertion macros used by the decoder RTL.
`ifndef PACKET_INTEGER_DECODER_CORE_ASSERT_SVH
`define PACKET_INTEGER_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PIDEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("decoder assertion failed");
`define PIDEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("decoder assertion failed");
`else
`define PIDEC_ASSERT(lbl, clk, rst_n, prop)
`define PIDEC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/pidec_pkg.sv
`default_nettype none

package pidec_pkg;

    localparam logic       MODE_COMPACT = 1'b0;
    localparam logic       MODE_VARINT  = 1'b1;

    localparam logic [7:0] ESC_SHORT = 8'h80;
    localparam logic [7:0] ESC_LONG  = 8'h81;

    localparam logic [31:0] SIGN_FILL = 32'hF000_0000;

    localparam logic [2:0] CNT_ONE       = 3'd1;
    localparam logic [2:0] CNT_SHORT_ESC = 3'd3;
    localparam logic [2:0] CNT_VARINT    = 3'd4;
    localparam logic [2:0] CNT_LONG_ESC  = 3'd5;
    localparam logic [2:0] SEEN_MAX      = 3'd4;
    localparam logic [2:0] VARINT_LAST   = 3'd3;

    typedef struct packed {
        logic               emit;
        logic signed [31:0] value;
        logic [2:0]         byte_count;
    } t_result;

    typedef struct packed {
        logic valid;
        logic out_free;
    } t_flow;

endpackage

`default_nettype wire

>>> rtl/pidec_in_stage.sv
`default_nettype none

module pidec_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_data
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       load;

    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/pidec_step.sv
`default_nettype none
`include "packet_integer_decoder_core_assert.svh"

module pidec_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pidec_pkg::t_flow i_flow,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_cfg_wr,
    input  wire logic           i_cfg_mode,
    output logic                o_advance,
    output pidec_pkg::t_result  o_result
);

    import pidec_pkg::*;

    logic        r_mode;
    logic [2:0]  r_seen;
    logic [31:0] r_acc;
    logic        r_long;
    logic [2:0]  n_seen;
    logic [31:0] n_acc;
    logic        n_long;

    logic [2:0]  k;
    logic [2:0]  k_next;
    logic [31:0] acc;
    logic        long_esc;
    logic [31:0] part;
    logic [31:0] acc_new;
    logic [31:0] top_sum;
    t_result     res;

    always_comb begin
        k        = r_seen;
        acc      = r_acc;
        long_esc = r_long;
        if (r_seen > SEEN_MAX) begin
            k        = '0;
            acc      = '0;
            long_esc = 1'b0;
        end
        k_next  = k + 3'd1;
        top_sum = acc + {3'b000, i_byte, 21'd0};
        part    = '0;
        if (r_mode == MODE_VARINT) begin
            case (k)
                3'd0:    part = {25'd0, i_byte[6:0]};
                3'd1:    part = {18'd0, i_byte[6:0], 7'd0};
                3'd2:    part = {11'd0, i_byte[6:0], 14'd0};
                default: part = '0;
            endcase
        end else begin
            case (k)
                3'd1:    part = {24'd0, i_byte};
                3'd2:    part = {16'd0, i_byte, 8'd0};
                3'd3:    part = {8'd0, i_byte, 16'd0};
                3'd4:    part = {i_byte, 24'd0};
                default: part = '0;
            endcase
        end
        acc_new = acc | part;

        res    = '0;
        n_seen = k;
        n_acc  = acc;
        n_long = long_esc;
        if (r_mode == MODE_VARINT) begin
            if (k >= VARINT_LAST) begin
                res.emit       = 1'b1;
                res.value      = top_sum[28] ? (top_sum | SIGN_FILL) : top_sum;
                res.byte_count = CNT_VARINT;
            end else if (!i_byte[7]) begin
                res.emit       = 1'b1;
                res.value      = acc_new;
                res.byte_count = k_next;
            end else begin
                n_seen = k_next;
                n_acc  = acc_new;
            end
        end else begin
            if (k == 3'd0) begin
                if (i_byte == ESC_SHORT || i_byte == ESC_LONG) begin
                    n_long = (i_byte == ESC_LONG);
                    n_acc  = '0;
                    n_seen = 3'd1;
                end else begin
                    res.emit       = 1'b1;
                    res.value      = {{24{i_byte[7]}}, i_byte};
                    res.byte_count = CNT_ONE;
                end
            end else if (!long_esc && k_next == CNT_SHORT_ESC) begin
                res.emit       = 1'b1;
                res.value      = {{16{acc_new[15]}}, acc_new[15:0]};
                res.byte_count = CNT_SHORT_ESC;
            end else if (long_esc && k_next == CNT_LONG_ESC) begin
                res.emit       = 1'b1;
                res.value      = acc_new;
                res.byte_count = CNT_LONG_ESC;
            end else begin
                n_seen = k_next;
                n_acc  = acc_new;
            end
        end
        if (res.emit) begin
            n_seen = '0;
            n_acc  = '0;
            n_long = 1'b0;
        end
    end

    assign o_advance = i_flow.valid && (i_flow.out_free || !res.emit);
    assign o_result  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COMPACT;
            r_seen <= '0;
            r_acc  <= '0;
            r_long <= 1'b0;
        end else if (i_cfg_wr) begin
            r_mode <= i_cfg_mode;
            r_seen <= '0;
            r_acc  <= '0;
            r_long <= 1'b0;
        end else if (o_advance) begin
            r_seen <= n_seen;
            r_acc  <= n_acc;
            r_long <= n_long;
        end
    end

    `PIDEC_ASSERT_ALWAYS(a_seen_bound, i_clk, !i_rst_n || r_seen <= SEEN_MAX)
    `PIDEC_ASSERT(a_varint_seen, i_clk, i_rst_n, r_mode == MODE_VARINT |-> r_seen <= VARINT_LAST)
    `PIDEC_ASSERT(a_emit_clears, i_clk, i_rst_n, o_advance && res.emit |=> r_seen == 3'd0)
    `PIDEC_ASSERT(a_count_range, i_clk, i_rst_n, res.emit |-> res.byte_count != 3'd0 && res.byte_count <= CNT_LONG_ESC)

endmodule

`default_nettype wire

>>> rtl/pidec_out_stage.sv
`default_nettype none

module pidec_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire pidec_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_free,
    output logic signed [31:0]     o_value,
    output logic [2:0]             o_byte_count
);

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic [2:0]         r_byte_count;
    logic               load;

    assign o_free = !r_valid || i_ready;
    assign load   = i_advance && i_result.emit;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value      <= i_result.value;
            r_byte_count <= i_result.byte_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_byte_count = r_byte_count;

endmodule

`default_nettype wire

>>> rtl/packet_integer_decoder_core.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] in_byte
// m_axis    out  tdata[31:0] value, [34:32] byte_count, [39:35] zero
// cfg       in   i_cfg_data format_mode (0 compact, 1 varint)
//
// One byte is taken per cycle unless a completing byte waits on a full result register;
// a beat that completes a value reaches m_axis via the input, then the result register.
// The input register advances whenever the result register is empty or drained.
// Bytes that complete no value advance even while a result waits.
// Reset clears the mode to compact and drops any partial value.
`default_nettype none

module packet_integer_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] value, [34:32] byte_count
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    import pidec_pkg::*;

    logic               in_valid;
    logic [7:0]         in_byte;
    logic               advance;
    logic               out_free;
    t_flow              flow;
    t_result            result;
    logic signed [31:0] out_value;
    logic [2:0]         out_count;

    assign o_cfg_ready = 1'b1;

    pidec_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_data    (in_byte)
    );

    assign flow = '{valid: in_valid, out_free: out_free};

    pidec_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (flow),
        .i_byte     (in_byte),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_mode (i_cfg_data),
        .o_advance  (advance),
        .o_result   (result)
    );

    pidec_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_result     (result),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_free       (out_free),
        .o_value      (out_value),
        .o_byte_count (out_count)
    );

    assign m_axis_tdata = {5'd0, out_count, out_value};

endmodule

`default_nettype wire

>>> tb/packet_integer_decoder_checker.sv
`timescale 1ns / 100ps

module packet_integer_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [39:0] i_out_data,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_drain_done,
    output int               o_pending,
    output int               o_fail_count
);

    import pidec_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         byte_count;
    } t_decoded_int;

    t_decoded_int expected_values[$];

    logic        fmt_mode;
    logic [2:0]  seen_count;
    logic [31:0] accum;
    logic        long_esc;
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("checker @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_partial();
        seen_count = 3'd0;
        accum      = 32'd0;
        long_esc   = 1'b0;
    endtask

    task automatic push_value(input logic [31:0] v, input logic [2:0] n);
        t_decoded_int item;
        item.value      = v;
        item.byte_count = n;
        expected_values.push_back(item);
        clear_partial();
    endtask

    task automatic decode_stream_byte(input logic [7:0] b);
        logic [2:0]  next_seen;
        logic [31:0] v;
        if (fmt_mode == MODE_VARINT) begin
            if (seen_count >= VARINT_LAST) begin
                v = accum + ({24'd0, b} << 21);
                if (v[28]) begin
                    v = v | SIGN_FILL;
                end
                push_value(v, CNT_VARINT);
            end else begin
                accum = accum | ({25'd0, b[6:0]} << (7 * seen_count));
                if (!b[7]) begin
                    push_value(accum, seen_count + 3'd1);
                end else begin
                    seen_count = seen_count + 3'd1;
                end
            end
        end else if (seen_count == 3'd0) begin
            if (b == ESC_SHORT || b == ESC_LONG) begin
                long_esc   = (b == ESC_LONG);
                accum      = 32'd0;
                seen_count = 3'd1;
            end else begin
                push_value({{24{b[7]}}, b}, CNT_ONE);
            end
        end else begin
            accum     = accum | ({24'd0, b} << (8 * (seen_count - 3'd1)));
            next_seen = seen_count + 3'd1;
            if (!long_esc && next_seen == CNT_SHORT_ESC) begin
                v = {{16{accum[15]}}, accum[15:0]};
                push_value(v, CNT_SHORT_ESC);
            end else if (long_esc && next_seen == CNT_LONG_ESC) begin
                push_value(accum, CNT_LONG_ESC);
            end else begin
                seen_count = next_seen;
            end
        end
    endtask

    task automatic check_result(input logic [39:0] beat);
        t_decoded_int want;
        if (expected_values.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", beat));
        end else begin
            want = expected_values.pop_front();
            if (beat[31:0] !== want.value) begin
                report_mismatch($sformatf("value %h, expected %h", beat[31:0], want.value));
            end
            if (beat[34:32] !== want.byte_count) begin
                report_mismatch($sformatf("byte_count %0d, expected %0d",
                                          beat[34:32], want.byte_count));
            end
            if (beat[39:35] !== 5'd0) begin
                report_mismatch($sformatf("padding bits %b not zero", beat[39:35]));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_mode = MODE_COMPACT;
            clear_partial();
            expected_values.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                fmt_mode = i_cfg_data;
                clear_partial();
            end
            if (i_in_valid && i_in_ready) begin
                decode_stream_byte(i_in_data);
            end
            if (i_drain_done && expected_values.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_values.size()));
            end
        end
        o_pending <= expected_values.size();
    end

endmodule

>>> tb/tb_packet_integer_decoder_core.sv
`timescale 1ns / 100ps

module tb_packet_integer_decoder_core;
    import pidec_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire logic   s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    wire logic   m_axis_tvalid;
    logic        m_axis_tready;
    wire logic [39:0] m_axis_tdata;   // [31:0] value, [34:32] byte_count
    logic        i_cfg_valid;
    wire logic   o_cfg_ready;
    logic        i_cfg_data;
    logic        drain_done;

    int pending;
    int fail_count;
    int bytes_sent = 0;
    bit idle_on = 1'b1;
    int hold_requests = 0;
    logic cur_mode = MODE_COMPACT;

    always #5 i_clk = ~i_clk;

    packet_integer_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    packet_integer_decoder_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_drain_done (drain_done),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_compact_value();
        int kind;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            b = 8'($urandom_range(0, 255));
            while (b == ESC_SHORT || b == ESC_LONG) b = 8'($urandom_range(0, 255));
            send_byte(b);
        end else begin
            send_byte((kind < 8) ? ESC_SHORT : ESC_LONG);
            repeat ((kind < 8) ? 2 : 4) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_varint_value();
        int len;
        logic [7:0] b;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i < 3) begin
                b[7] = (i < len - 1);
            end
            send_byte(b);
        end
    endtask

    // A value cut short before a mode write, which must drop it.
    task automatic send_partial();
        logic [7:0] b;
        if (cur_mode == MODE_VARINT) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                b[7] = 1'b1;
                send_byte(b);
            end
        end else if ($urandom_range(0, 1) == 0) begin
            send_byte(ESC_SHORT);
            repeat ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(ESC_LONG);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    initial begin : receiver
        int stall;
        int hold;
        int hold_taken;
        stall      = 0;
        hold       = 0;
        hold_taken = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_taken) begin
                hold       = 300;
                hold_taken = hold_requests;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        int guard;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        drain_done    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Compact mode straight out of reset.
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(ESC_SHORT); send_byte(8'hFF); send_byte(8'h7F);
        send_byte(ESC_SHORT); send_byte(8'h00); send_byte(8'h80);
        send_byte(ESC_LONG);
        repeat (4) send_byte(8'hFF);
        send_byte(ESC_LONG); send_byte(8'h12);
        write_mode(MODE_VARINT);
        send_byte(8'h7F);
        send_byte(8'h80); send_byte(8'h01);
        repeat (4) send_byte(8'hFF);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                idle_on = 1'b0;
            end
            if (ph < 3) begin
                write_mode((ph == 1) ? MODE_VARINT : MODE_COMPACT);
            end else begin
                write_mode(1'($urandom_range(0, 1)));
            end
            if (ph == 2) begin
                hold_requests++;
                repeat (40) send_byte(8'($urandom_range(0, 127)));
            end
            phase_end = bytes_sent + 200;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(8'($urandom_range(0, 255)));
                end else if (cur_mode == MODE_VARINT) begin
                    send_varint_value();
                end else begin
                    send_compact_value();
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                send_partial();
            end
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        drain_done <= 1'b1;
        @(posedge i_clk);
        drain_done <= 1'b0;
        @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
